/* sv/tcce_pkg.sv */
// Shared types and constants for the text console character engine.
// Holds field widths, character codes, blank cell values and the sequencer state type.
// No dependencies.
package tcce_pkg;

    // Default screen geometry
    localparam int TCCE_COLUMNS = 80;
    localparam int TCCE_ROWS    = 25;

    // Field widths of the channels
    localparam int OP_W   = 1;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int RROW_W = 5;
    localparam int RCOL_W = 7;
    localparam int IDX_W  = 11;
    localparam int CNT_W  = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    // Control characters
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Blank cell and reset attribute
    localparam logic [ATTR_W-1:0] BLANK_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, CHAR_SPACE};

    // Tab stops every eight columns
    localparam int TAB_STOP = 8;
    localparam int TAB_BITS = $clog2(TAB_STOP);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRINT,
        ST_SWEEP,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

/* sv/tcce_if.sv */
// Channel interfaces of the text console character engine: input, result and attribute write.
// Each carries valid, ready and its payload; a transaction completes when both are high.
// Depends on tcce_pkg.
interface tcce_in_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;

    modport source (output valid, op, char_code, read_row, read_col, input ready);
    modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

interface tcce_out_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [RROW_W-1:0] cursor_row_out;
    logic [RCOL_W-1:0] cursor_col_out;
    logic [IDX_W-1:0]  cursor_index;

    modport source (output valid, cell_char, cell_attr, cursor_row_out, cursor_col_out,
                    cursor_index, input ready);
    modport sink   (input valid, cell_char, cell_attr, cursor_row_out, cursor_col_out,
                    cursor_index, output ready);
endinterface

interface tcce_cfg_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* sv/text_console_character_engine.sv */
// Top level of the text console character engine: cursor sequencer around the cell store.
// Depends on tcce_pkg, the channel interfaces and tcce_cell_mem.
//
// The block keeps a ROWS x COLUMNS screen of 16-bit cells (attribute high byte, character
// low byte) in one single-port-write memory, and a cursor. Rows are kept in a ring: a
// scroll moves the top-row pointer and blanks the new bottom row, one cell per cycle.
// After reset the block sweeps the whole memory with blank cells, one cell per cycle,
// and takes no item until that is done; attribute writes are taken at any time. Work per
// item, from acceptance to a result ready in the output register: a printable byte or a
// backspace writes its cell in the print state (a backspace at the origin writes nothing),
// a newline goes straight to the done state, a cell read passes the read state, and a tab
// writes one space per print step (up to 8). Every scroll adds a sweep of the bottom row.
// One item is worked on at a time; the next item is accepted while the previous result waits to be taken.
module text_console_character_engine
    import tcce_pkg::*;
#(
    parameter int COLUMNS = TCCE_COLUMNS,
    parameter int ROWS    = TCCE_ROWS
)
(
    input  logic     clk,
    input  logic     rst_n,
    tcce_in_if.sink  in_ch,
    tcce_out_if.source out_ch,
    tcce_cfg_if.sink cfg_ch
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RSW   = ((RW > RROW_W) ? RW : RROW_W) + 1;

    // Physical address of a cell in the ring of rows
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] col);
        return AW'(prow) * AW'(COLUMNS) + AW'(col);
    endfunction

    state_t state_reg, state_next;

    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     prow_reg, prow_next;
    logic [RW-1:0]     top_reg, top_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              out_valid_reg, out_valid_next;

    logic [CELL_W-1:0] wdata_reg, wdata_next;
    logic              adv_reg, adv_next;
    logic [RW-1:0]     sweep_prow_reg, sweep_prow_next;
    logic [CW-1:0]     sweep_col_reg, sweep_col_next;
    logic              rd_op_reg, rd_op_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [RW-1:0]     rd_prow_reg, rd_prow_next;
    logic [CW-1:0]     rd_col_reg, rd_col_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [ATTR_W-1:0] out_attr_reg, out_attr_next;
    logic [RROW_W-1:0] out_row_reg, out_row_next;
    logic [RCOL_W-1:0] out_col_reg, out_col_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;

    logic              in_ready;
    logic              in_acc;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    logic              col_last;
    logic              row_last;
    logic              print_scroll;
    logic              sweep_last;
    logic              clr_last;
    logic              out_free;
    logic              bs_origin;
    logic [CNT_W-1:0]  cnt_dec;
    logic [RW-1:0]     top_inc;
    logic [RW-1:0]     prow_inc;
    logic [RW-1:0]     prow_dec;
    logic [RSW-1:0]    rr_sum;
    logic [RSW-1:0]    rr_wrap;

    // Cell store
    tcce_cell_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Shared conditions
    assign in_acc       = in_ch.valid && in_ready;
    assign col_last     = (col_reg == CW'(COLUMNS - 1));
    assign row_last     = (row_reg == RW'(ROWS - 1));
    assign print_scroll = adv_reg && col_last && row_last;
    assign sweep_last   = (sweep_col_reg == CW'(COLUMNS - 1));
    assign clr_last     = (clr_addr_reg == AW'(DEPTH - 1));
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign bs_origin    = (row_reg == '0) && (col_reg == '0);
    assign cnt_dec      = cnt_reg - CNT_W'(1);
    assign top_inc      = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + RW'(1);
    assign prow_inc     = (prow_reg == RW'(ROWS - 1)) ? '0 : prow_reg + RW'(1);
    assign prow_dec     = (prow_reg == '0) ? RW'(ROWS - 1) : prow_reg - RW'(1);

    // Map the requested screen row onto the ring
    assign rr_sum  = RSW'(top_reg) + RSW'(in_ch.read_row);
    assign rr_wrap = (rr_sum >= RSW'(ROWS)) ? rr_sum - RSW'(ROWS) : rr_sum;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.op == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (in_ch.char_code == CHAR_NL)
                    begin
                        state_next = row_last ? ST_SWEEP : ST_DONE;
                    end
                    else if (in_ch.char_code == CHAR_BS)
                    begin
                        state_next = bs_origin ? ST_DONE : ST_PRINT;
                    end
                    else
                    begin
                        state_next = ST_PRINT;
                    end
                end
            end
            ST_PRINT:
            begin
                if (print_scroll)
                begin
                    state_next = ST_SWEEP;
                end
                else if (cnt_dec != '0)
                begin
                    state_next = ST_PRINT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = (cnt_reg != '0) ? ST_PRINT : ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Memory port and handshake outputs
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = BLANK_CELL;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_PRINT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(prow_reg, col_reg);
                mem_wdata = wdata_reg;
            end
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(sweep_prow_reg, sweep_col_reg);
            end
            ST_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = cell_addr(rd_prow_reg, rd_col_reg);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Cursor, ring pointer and item working registers
    always_comb
    begin
        logic nl_do;

        nl_do           = 1'b0;
        row_next        = row_reg;
        col_next        = col_reg;
        prow_next       = prow_reg;
        top_next        = top_reg;
        cnt_next        = cnt_reg;
        clr_addr_next   = clr_addr_reg;
        wdata_next      = wdata_reg;
        adv_next        = adv_reg;
        sweep_prow_next = sweep_prow_reg;
        sweep_col_next  = sweep_col_reg;
        rd_op_next      = rd_op_reg;
        rd_ok_next      = rd_ok_reg;
        rd_prow_next    = rd_prow_reg;
        rd_col_next     = rd_col_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    rd_op_next   = (in_ch.op == OP_READ);
                    rd_ok_next   = (int'(in_ch.read_row) < ROWS) &&
                                   (int'(in_ch.read_col) < COLUMNS);
                    rd_prow_next = RW'(rr_wrap);
                    rd_col_next  = CW'(in_ch.read_col);
                    if (in_ch.op == OP_PUT)
                    begin
                        if (in_ch.char_code == CHAR_NL)
                        begin
                            nl_do    = 1'b1;
                            cnt_next = '0;
                        end
                        else if (in_ch.char_code == CHAR_TAB)
                        begin
                            wdata_next = {attr_reg, CHAR_SPACE};
                            adv_next   = 1'b1;
                            cnt_next   = CNT_W'(TAB_STOP) - CNT_W'(col_reg[TAB_BITS-1:0]);
                        end
                        else if (in_ch.char_code == CHAR_BS)
                        begin
                            // Step back, across a line end, then blank that cell
                            wdata_next = BLANK_CELL;
                            adv_next   = 1'b0;
                            cnt_next   = CNT_W'(1);
                            if (!bs_origin)
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next = col_reg - CW'(1);
                                end
                                else
                                begin
                                    row_next  = row_reg - RW'(1);
                                    prow_next = prow_dec;
                                    col_next  = CW'(COLUMNS - 1);
                                end
                            end
                        end
                        else
                        begin
                            wdata_next = {attr_reg, in_ch.char_code};
                            adv_next   = 1'b1;
                            cnt_next   = CNT_W'(1);
                        end
                    end
                end
            end
            ST_PRINT:
            begin
                cnt_next = cnt_dec;
                if (adv_reg)
                begin
                    if (col_last)
                    begin
                        nl_do = 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end
            ST_SWEEP:
            begin
                sweep_col_next = sweep_col_reg + CW'(1);
            end
            default:
            begin
                nl_do = 1'b0;
            end
        endcase

        // New line: the old top row becomes the blank bottom row when scrolling
        if (nl_do)
        begin
            col_next = '0;
            if (row_last)
            begin
                top_next        = top_inc;
                prow_next       = top_reg;
                sweep_prow_next = top_reg;
                sweep_col_next  = '0;
            end
            else
            begin
                row_next  = row_reg + RW'(1);
                prow_next = prow_inc;
            end
        end
    end

    // Attribute register write
    assign cfg_ch.ready = 1'b1;
    assign attr_next    = cfg_ch.valid ? cfg_ch.data : attr_reg;

    // Result register: load once the item is finished and the slot is free
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_idx_next   = out_idx_reg;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            out_char_next  = (rd_op_reg && rd_ok_reg) ? mem_rdata[CHAR_W-1:0] : '0;
            out_attr_next  = (rd_op_reg && rd_ok_reg) ? mem_rdata[CELL_W-1:CHAR_W] : '0;
            out_row_next   = RROW_W'(row_reg);
            out_col_next   = RCOL_W'(col_reg);
            out_idx_next   = IDX_W'(int'(row_reg) * COLUMNS + int'(col_reg));
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            prow_reg      <= '0;
            top_reg       <= '0;
            attr_reg      <= BLANK_ATTR;
            cnt_reg       <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            prow_reg      <= prow_next;
            top_reg       <= top_next;
            attr_reg      <= attr_next;
            cnt_reg       <= cnt_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wdata_reg      <= wdata_next;
        adv_reg        <= adv_next;
        sweep_prow_reg <= sweep_prow_next;
        sweep_col_reg  <= sweep_col_next;
        rd_op_reg      <= rd_op_next;
        rd_ok_reg      <= rd_ok_next;
        rd_prow_reg    <= rd_prow_next;
        rd_col_reg     <= rd_col_next;
        out_char_reg   <= out_char_next;
        out_attr_reg   <= out_attr_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_idx_reg    <= out_idx_next;
    end

    // Drive the channels
    assign in_ch.ready           = in_ready;
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.cell_char      = out_char_reg;
    assign out_ch.cell_attr      = out_attr_reg;
    assign out_ch.cursor_row_out = out_row_reg;
    assign out_ch.cursor_col_out = out_col_reg;
    assign out_ch.cursor_index   = out_idx_reg;

endmodule

/* sv/tcce_cell_mem.sv */
// Text cell store: one write port and one read port, read data registered.
// Depends on tcce_pkg for the cell width.
module tcce_cell_mem
    import tcce_pkg::*;
#(
    parameter int DEPTH = TCCE_ROWS * TCCE_COLUMNS,
    parameter int AW    = $clog2(TCCE_ROWS * TCCE_COLUMNS)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/tcce_checker.sv */
// Port-level checks for the text console character engine, bound to the top level.
// Depends on tcce_pkg and text_console_character_engine.
module tcce_checker
    import tcce_pkg::*;
#(
    parameter int COLUMNS = TCCE_COLUMNS,
    parameter int ROWS    = TCCE_ROWS
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [RROW_W-1:0] cursor_row_out,
    input logic [RCOL_W-1:0] cursor_col_out,
    input logic [IDX_W-1:0]  cursor_index
);

    // Take one transaction at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken in the cycle after a transaction");

    // Keep the reported column on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(cursor_col_out) < COLUMNS))
        else $error("cursor column beyond the last column");

    // Keep the linear index consistent with row and column
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ROWS <= 32) |->
            cursor_index == IDX_W'(int'(cursor_row_out) * COLUMNS + int'(cursor_col_out)))
        else $error("cursor index does not match row and column");

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_index))
        else $error("stalled result changed or dropped");

endmodule

bind text_console_character_engine tcce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcce_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .cursor_row_out (out_ch.cursor_row_out),
    .cursor_col_out (out_ch.cursor_col_out),
    .cursor_index   (out_ch.cursor_index)
);
